// ===== sv/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// No dependencies; used by i2cm_front, i2cm_seq and i2c_master_byte_engine.
`default_nettype none

package i2cm_pkg;

    // Command codes carried in the request kind field
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic CFG_DELAY   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] DELAY_RESET   = 16'd25;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd250;

    // Bits per byte on the bus
    localparam logic [3:0] BYTE_BITS = 4'd8;

    // Request queue between front and sequencer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified tick request
    typedef struct packed {
        logic       take_cmd;
        cmd_t       cmd;
        logic [7:0] wr_data;
        logic       nack_bit;
        logic       sda_sample;
    } item_t;

    // One tick result
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_received;
        logic       ack_timed_out;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/i2cm_front.sv =====
// Front end: unpacks and classifies tick requests and holds them in a short queue.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [15:0]     in_data,   // wr_data[7:0], nack_bit[8], sda_sample[9], pad
    input  wire logic [2:0]      in_user,   // cmd_valid[0], req_type[2:1]
    output logic                 q_valid,
    input  wire logic            q_pop,
    output i2cm_pkg::item_t      q_item
);

    i2cm_pkg::item_t                  mem [i2cm_pkg::QDEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [i2cm_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [i2cm_pkg::QCNT_W-1:0]      count_reg;
    logic [i2cm_pkg::QCNT_W-1:0]      count_next;
    i2cm_pkg::item_t                  item;
    logic                             push;
    logic                             pop;

    // Classify the incoming request
    always_comb
    begin
        item.take_cmd   = in_user[0];
        item.cmd        = i2cm_pkg::cmd_t'(in_user[2:1]);
        item.wr_data    = in_data[7:0];
        item.nack_bit   = in_data[8];
        item.sda_sample = in_data[9];
    end

    assign in_ready = (count_reg != i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;
    assign q_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= item;
        end
    end

    // Advance the pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH))
        else $error("request queue fill count beyond depth");

    a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty request queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

// ===== sv/i2cm_seq.sv =====
// Back end: bus sequencer that steps once per queued tick, plus result register.
// Depends on i2cm_pkg; fed by i2cm_front.
`default_nettype none

module i2cm_seq
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_addr,
    input  wire logic [15:0]     cfg_wdata,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire i2cm_pkg::item_t q_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output i2cm_pkg::res_t       out_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_S0, PH_S1, PH_S2, PH_P0, PH_P1, PH_P2, PH_W0,
        PH_W1, PH_W2, PH_A0, PH_A1, PH_A2, PH_R0, PH_R1, PH_FIN
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [3:0]      bit_count_reg, bit_count_next;
    logic [7:0]      shift_reg, shift_next;
    logic [15:0]     delay_count_reg, delay_count_next;
    logic [7:0]      poll_count_reg, poll_count_next;
    logic            scl_reg, scl_next;
    logic            sda_reg, sda_next;
    logic            sda_oe_reg, sda_oe_next;
    i2cm_pkg::cmd_t  cur_cmd_reg, cur_cmd_next;
    logic            nack_hold_reg, nack_hold_next;
    logic [7:0]      rd_reg, rd_next;
    logic            ack_ok_reg, ack_ok_next;
    logic            ack_late_reg, ack_late_next;
    logic [15:0]     delay_ticks_reg;
    logic [7:0]      ack_timeout_reg;
    logic            out_valid_reg;
    i2cm_pkg::res_t  res_reg;
    i2cm_pkg::res_t  res_next;
    logic            done;
    logic [15:0]     arm;
    logic [3:0]      bit_inc;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;
    assign arm       = (delay_ticks_reg != '0) ? (delay_ticks_reg - 16'd1) : '0;
    assign bit_inc   = bit_count_reg + 4'd1;

    // Step the bus sequence by one tick
    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        shift_next       = shift_reg;
        delay_count_next = delay_count_reg;
        poll_count_next  = poll_count_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_oe_next      = sda_oe_reg;
        cur_cmd_next     = cur_cmd_reg;
        nack_hold_next   = nack_hold_reg;
        rd_next          = rd_reg;
        ack_ok_next      = ack_ok_reg;
        ack_late_next    = ack_late_reg;
        done             = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (q_item.take_cmd)
            begin
                cur_cmd_next     = q_item.cmd;
                delay_count_next = '0;
                bit_count_next   = '0;
                poll_count_next  = '0;
                unique case (q_item.cmd)
                    i2cm_pkg::CMD_START: phase_next = PH_S0;
                    i2cm_pkg::CMD_STOP:  phase_next = PH_P0;
                    i2cm_pkg::CMD_WRITE:
                    begin
                        shift_next    = q_item.wr_data;
                        ack_ok_next   = 1'b0;
                        ack_late_next = 1'b0;
                        phase_next    = PH_W0;
                    end
                    default:
                    begin
                        shift_next     = '0;
                        nack_hold_next = q_item.nack_bit;
                        phase_next     = PH_R0;
                    end
                endcase
            end
        end
        else if (delay_count_reg != '0)
        begin
            delay_count_next = delay_count_reg - 16'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_S0:
                begin
                    sda_next = 1'b1; scl_next = 1'b1; sda_oe_next = 1'b1;
                    delay_count_next = arm; phase_next = PH_S1;
                end
                PH_S1:
                begin
                    sda_next = 1'b0;
                    delay_count_next = arm; phase_next = PH_S2;
                end
                PH_S2:
                begin
                    scl_next = 1'b0;
                    done = 1'b1; phase_next = PH_IDLE;
                end
                PH_P0:
                begin
                    scl_next = 1'b0; sda_next = 1'b0; sda_oe_next = 1'b1;
                    delay_count_next = arm; phase_next = PH_P1;
                end
                PH_P1:
                begin
                    scl_next = 1'b1;
                    delay_count_next = arm; phase_next = PH_P2;
                end
                PH_P2:
                begin
                    sda_next = 1'b1;
                    done = 1'b1; phase_next = PH_IDLE;
                end
                PH_W0:
                begin
                    sda_oe_next = 1'b1;
                    sda_next = (cur_cmd_reg == i2cm_pkg::CMD_READ) ? nack_hold_reg
                                                                    : shift_reg[7];
                    delay_count_next = arm; phase_next = PH_W1;
                end
                PH_W1:
                begin
                    scl_next = 1'b1;
                    delay_count_next = arm; phase_next = PH_W2;
                end
                PH_W2:
                begin
                    scl_next = 1'b0;
                    delay_count_next = arm;
                    if (cur_cmd_reg == i2cm_pkg::CMD_READ)
                    begin
                        phase_next = PH_FIN;
                    end
                    else
                    begin
                        shift_next     = {shift_reg[6:0], 1'b0};
                        bit_count_next = bit_inc;
                        phase_next     = (bit_inc >= i2cm_pkg::BYTE_BITS) ? PH_A0 : PH_W0;
                    end
                end
                PH_A0:
                begin
                    sda_next = 1'b1; sda_oe_next = 1'b0;
                    delay_count_next = arm; phase_next = PH_A1;
                end
                PH_A1:
                begin
                    scl_next = 1'b1; poll_count_next = '0;
                    delay_count_next = arm; phase_next = PH_A2;
                end
                PH_A2:
                begin
                    if (!q_item.sda_sample)
                    begin
                        scl_next = 1'b0; sda_oe_next = 1'b1;
                        ack_ok_next = 1'b1;
                        done = 1'b1; phase_next = PH_IDLE;
                    end
                    else if (poll_count_reg >= ack_timeout_reg)
                    begin
                        // ACK wait expired: release the bus with a stop
                        scl_next = 1'b0; sda_oe_next = 1'b1;
                        ack_late_next = 1'b1;
                        phase_next = PH_P0;
                    end
                    else
                    begin
                        poll_count_next = poll_count_reg + 8'd1;
                    end
                end
                PH_R0:
                begin
                    sda_oe_next = 1'b0; scl_next = 1'b1;
                    shift_next = {shift_reg[6:0], q_item.sda_sample};
                    delay_count_next = arm; phase_next = PH_R1;
                end
                PH_R1:
                begin
                    scl_next = 1'b0;
                    bit_count_next = bit_inc;
                    delay_count_next = arm;
                    phase_next = (bit_inc >= i2cm_pkg::BYTE_BITS) ? PH_W0 : PH_R0;
                end
                PH_FIN:
                begin
                    if (cur_cmd_reg == i2cm_pkg::CMD_READ)
                    begin
                        rd_next = shift_reg;
                    end
                    done = 1'b1; phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Assemble the tick result from the updated state
    always_comb
    begin
        res_next.scl_level     = scl_next;
        res_next.sda_level     = sda_next;
        res_next.sda_drive     = sda_oe_next;
        res_next.busy_res      = (phase_next != PH_IDLE);
        res_next.done_res      = done;
        res_next.rd_data       = rd_next;
        res_next.ack_received  = ack_ok_next;
        res_next.ack_timed_out = ack_late_next;
    end

    // Hold sequencer state, configuration and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            delay_count_reg <= '0;
            poll_count_reg  <= '0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_oe_reg      <= 1'b1;
            cur_cmd_reg     <= i2cm_pkg::CMD_START;
            nack_hold_reg   <= 1'b0;
            rd_reg          <= '0;
            ack_ok_reg      <= 1'b0;
            ack_late_reg    <= 1'b0;
            delay_ticks_reg <= i2cm_pkg::DELAY_RESET;
            ack_timeout_reg <= i2cm_pkg::TIMEOUT_RESET;
            out_valid_reg   <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    i2cm_pkg::CFG_DELAY:   delay_ticks_reg <= cfg_wdata;
                    i2cm_pkg::CFG_TIMEOUT: ack_timeout_reg <= cfg_wdata[7:0];
                    default:               delay_ticks_reg <= delay_ticks_reg;
                endcase
            end
            if (q_pop)
            begin
                phase_reg       <= phase_next;
                bit_count_reg   <= bit_count_next;
                shift_reg       <= shift_next;
                delay_count_reg <= delay_count_next;
                poll_count_reg  <= poll_count_next;
                scl_reg         <= scl_next;
                sda_reg         <= sda_next;
                sda_oe_reg      <= sda_oe_next;
                cur_cmd_reg     <= cur_cmd_next;
                nack_hold_reg   <= nack_hold_next;
                rd_reg          <= rd_next;
                ack_ok_reg      <= ack_ok_next;
                ack_late_reg    <= ack_late_next;
                res_reg         <= res_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= i2cm_pkg::BYTE_BITS)
        else $error("bit counter ran past one byte");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && done) |=> (phase_reg == PH_IDLE))
        else $error("command finished but sequencer not idle");

    a_release_phases: assert property (@(posedge clk) disable iff (!rst_n)
        !sda_oe_reg |-> (phase_reg == PH_A1 || phase_reg == PH_A2 ||
                         phase_reg == PH_R0 || phase_reg == PH_R1 ||
                         phase_reg == PH_W0))
        else $error("SDA released outside ACK poll or read");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> !res_reg.busy_res)
        else $error("done reported while still busy");

endmodule

`default_nettype wire

// ===== sv/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine: front queue feeding the bus sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_seq.
//
//  channel  | direction | fields
//  ---------+-----------+-------------------------------------------------------------
//  s_axis   | in        | tuser: cmd_valid, req_type; tdata: wr_data, nack_bit, sda_sample
//  m_axis   | out       | tdata: scl, sda, drive, busy, done, rd_data, ack, timeout
//  cfg      | in        | index 0 delay_ticks, index 1 ack_timeout; one write per cycle
//
// One request per cycle is taken while the queue has room, and one result per request
// comes out, in order. A request passes through the four-entry request queue, then
// through the sequencer into the result register. The sequencer steps once per request.
// Reset (rst_n low) idles the bus with SCL and SDA high and driven.
// A stalled m_axis fills the queue; s_axis_tready drops only when it is full.
`default_nettype none

module i2c_master_byte_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // wr_data[7:0], nack_bit[8], sda_sample[9], zero pad
    input  wire logic [2:0]  s_axis_tuser,   // cmd_valid[0], req_type[2:1]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // scl_level[0], sda_level[1], sda_drive[2],
                                             // busy_res[3], done_res[4], rd_data[12:5],
                                             // ack_received[13], ack_timed_out[14], zero pad
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    logic             q_valid;
    logic             q_pop;
    i2cm_pkg::item_t  q_item;
    i2cm_pkg::res_t   res;

    i2cm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .in_user  (s_axis_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    i2cm_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result, first field in the lowest bit
    assign m_axis_tdata = {1'b0, res.ack_timed_out, res.ack_received, res.rd_data,
                           res.done_res, res.busy_res, res.sda_drive, res.sda_level,
                           res.scl_level};

endmodule

`default_nettype wire

// ===== tb/sv/i2c_master_byte_engine_tb.sv =====
// Testbench for i2c_master_byte_engine: clock-tick requests in, one pin/status result out per tick.
// A tick-level model of the bus sequencer predicts every result; depends on i2cm_pkg and the RTL.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_TICKS   = 90;
    localparam int MAX_REPORTS    = 100;

    // One tick request as the generator sees it
    typedef struct packed {
        logic             take;
        i2cm_pkg::cmd_t   kind;
        logic [7:0]       data;
        logic             nack;
        logic             sda;
    } tick_t;

    // Result word, bit 0 upwards: scl, sda, drive, busy, done, rd_data, ack, timeout
    typedef struct packed {
        logic       late;
        logic       ack;
        logic [7:0] rd;
        logic       done;
        logic       busy;
        logic       oe;
        logic       sda;
        logic       scl;
    } pins_t;

    // Sequencer steps of the bus model
    typedef enum logic [4:0] {
        SEQ_IDLE, SEQ_S0, SEQ_S1, SEQ_S2, SEQ_P0, SEQ_P1, SEQ_P2,
        SEQ_W0, SEQ_W1, SEQ_W2, SEQ_A0, SEQ_A1, SEQ_A2, SEQ_R0, SEQ_R1, SEQ_FIN
    } seq_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // wr_data[7:0], nack_bit[8], sda_sample[9], zero pad
    logic [2:0]  s_axis_tuser = '0;   // cmd_valid[0], req_type[2:1]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // scl[0], sda[1], drive[2], busy[3], done[4],
                                      // rd_data[12:5], ack[13], timeout[14], zero pad
    logic        cfg_we = 1'b0;
    logic        cfg_addr = i2cm_pkg::CFG_DELAY;
    logic [15:0] cfg_wdata = '0;

    i2c_master_byte_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bus model state and its copy of the configuration
    seq_t           m_seq = SEQ_IDLE;
    logic [3:0]     m_bits = '0;
    logic [7:0]     m_shift = '0;
    logic [15:0]    m_wait = '0;
    logic [7:0]     m_polls = '0;
    logic           m_scl = 1'b1;
    logic           m_sda = 1'b1;
    logic           m_oe = 1'b1;
    i2cm_pkg::cmd_t m_cmd = i2cm_pkg::CMD_START;
    logic           m_nack = 1'b0;
    logic [7:0]     m_rd = '0;
    logic           m_ack = 1'b0;
    logic           m_late = 1'b0;
    logic [15:0]    cfg_delay = i2cm_pkg::DELAY_RESET;
    logic [7:0]     cfg_timeout = i2cm_pkg::TIMEOUT_RESET;

    pins_t bus_expect[$];
    tick_t pending[$];
    tick_t on_bus;

    int failures = 0;
    int results_seen = 0;
    int queued_ticks = 0;
    int cmd_taken[4] = '{0, 0, 0, 0};
    int acks_seen = 0;
    int timeouts_seen = 0;
    int configs_applied = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_step = 0;
    int rx_mode = 0;
    logic [31:0] rx_pattern = '1;
    int stall_cycles = 0;

    // Reload value for the edge spacing counter; zero spacing acts as one
    function automatic logic [15:0] interval_reload();
        return (cfg_delay == 16'd0) ? 16'd0 : cfg_delay - 16'd1;
    endfunction

    // Advance the bus model by one tick and queue the expected pins and status
    task automatic advance_bus(tick_t t);
        logic  done_now;
        pins_t p;
        done_now = 1'b0;
        if (m_seq == SEQ_IDLE)
        begin
            if (t.take)
            begin
                m_cmd = t.kind;
                m_wait = '0;
                m_bits = '0;
                m_polls = '0;
                cmd_taken[int'(t.kind)]++;
                case (t.kind)
                    i2cm_pkg::CMD_START: m_seq = SEQ_S0;
                    i2cm_pkg::CMD_STOP:  m_seq = SEQ_P0;
                    i2cm_pkg::CMD_WRITE:
                    begin
                        m_shift = t.data;
                        m_ack = 1'b0;
                        m_late = 1'b0;
                        m_seq = SEQ_W0;
                    end
                    default:
                    begin
                        m_shift = '0;
                        m_nack = t.nack;
                        m_seq = SEQ_R0;
                    end
                endcase
            end
        end
        else if (m_wait != 16'd0)
        begin
            m_wait = m_wait - 16'd1;
        end
        else
        begin
            case (m_seq)
                SEQ_S0:
                begin
                    m_sda = 1'b1; m_scl = 1'b1; m_oe = 1'b1;
                    m_wait = interval_reload(); m_seq = SEQ_S1;
                end
                SEQ_S1:
                begin
                    m_sda = 1'b0;
                    m_wait = interval_reload(); m_seq = SEQ_S2;
                end
                SEQ_S2:
                begin
                    m_scl = 1'b0;
                    done_now = 1'b1; m_seq = SEQ_IDLE;
                end
                SEQ_P0:
                begin
                    m_scl = 1'b0; m_sda = 1'b0; m_oe = 1'b1;
                    m_wait = interval_reload(); m_seq = SEQ_P1;
                end
                SEQ_P1:
                begin
                    m_scl = 1'b1;
                    m_wait = interval_reload(); m_seq = SEQ_P2;
                end
                SEQ_P2:
                begin
                    m_sda = 1'b1;
                    done_now = 1'b1; m_seq = SEQ_IDLE;
                end
                SEQ_W0:
                begin
                    // a read reuses the bit slot to send its ACK/NACK
                    m_oe = 1'b1;
                    m_sda = (m_cmd == i2cm_pkg::CMD_READ) ? m_nack : m_shift[7];
                    m_wait = interval_reload(); m_seq = SEQ_W1;
                end
                SEQ_W1:
                begin
                    m_scl = 1'b1;
                    m_wait = interval_reload(); m_seq = SEQ_W2;
                end
                SEQ_W2:
                begin
                    m_scl = 1'b0;
                    m_wait = interval_reload();
                    if (m_cmd == i2cm_pkg::CMD_READ)
                    begin
                        m_seq = SEQ_FIN;
                    end
                    else
                    begin
                        m_shift = m_shift << 1;
                        m_bits = m_bits + 4'd1;
                        m_seq = (m_bits >= i2cm_pkg::BYTE_BITS) ? SEQ_A0 : SEQ_W0;
                    end
                end
                SEQ_A0:
                begin
                    m_sda = 1'b1; m_oe = 1'b0;
                    m_wait = interval_reload(); m_seq = SEQ_A1;
                end
                SEQ_A1:
                begin
                    m_scl = 1'b1; m_polls = '0;
                    m_wait = interval_reload(); m_seq = SEQ_A2;
                end
                SEQ_A2:
                begin
                    // poll for ACK; give up with a stop once the poll budget is spent
                    if (!t.sda)
                    begin
                        m_scl = 1'b0; m_oe = 1'b1; m_ack = 1'b1;
                        done_now = 1'b1; m_seq = SEQ_IDLE;
                        acks_seen++;
                    end
                    else if (m_polls >= cfg_timeout)
                    begin
                        m_scl = 1'b0; m_oe = 1'b1; m_late = 1'b1;
                        m_seq = SEQ_P0;
                        timeouts_seen++;
                    end
                    else
                    begin
                        m_polls = m_polls + 8'd1;
                    end
                end
                SEQ_R0:
                begin
                    m_oe = 1'b0; m_scl = 1'b1;
                    m_shift = {m_shift[6:0], t.sda};
                    m_wait = interval_reload(); m_seq = SEQ_R1;
                end
                SEQ_R1:
                begin
                    m_scl = 1'b0;
                    m_bits = m_bits + 4'd1;
                    m_wait = interval_reload();
                    m_seq = (m_bits >= i2cm_pkg::BYTE_BITS) ? SEQ_W0 : SEQ_R0;
                end
                SEQ_FIN:
                begin
                    if (m_cmd == i2cm_pkg::CMD_READ)
                        m_rd = m_shift;
                    done_now = 1'b1; m_seq = SEQ_IDLE;
                end
                default: m_seq = SEQ_IDLE;
            endcase
        end
        p.scl  = m_scl;
        p.sda  = m_sda;
        p.oe   = m_oe;
        p.busy = (m_seq != SEQ_IDLE);
        p.done = done_now;
        p.rd   = m_rd;
        p.ack  = m_ack;
        p.late = m_late;
        bus_expect.push_back(p);
    endtask

    // Choose the next burst length and the gap that follows it
    task automatic pick_pacing();
        if ($urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(64, 256);
            gap_left = 0;
        end
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 5);
        end
    endtask

    // Request driver: present pending ticks in bursts, feed the model on each accepted request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                advance_bus(on_bus);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    on_bus = pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, on_bus.sda, on_bus.nack, on_bus.data};
                    s_axis_tuser <= {on_bus.kind, on_bus.take};
                    if (burst_left > 1)
                        burst_left--;
                    else
                        pick_pacing();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side back-pressure: a fresh random stall pattern, redrawn from a step counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if ((rx_step % 64) == 0)
            begin
                rx_mode = $urandom_range(0, 2);
                rx_pattern = $urandom;
                if (rx_mode == 2)
                    rx_pattern = rx_pattern | (rx_pattern >> 1) | (rx_pattern << 3);
            end
            m_axis_tready <= (rx_mode == 0) ? 1'b1 : rx_pattern[rx_step % 32];
            rx_step++;
        end
    end

    // Report one field that differs from the prediction
    task automatic note_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %0h, got %0h",
                         $time, results_seen, name, want, got);
            else if (failures == MAX_REPORTS + 1)
                $display("%0t: further mismatches are counted but not shown", $time);
        end
    endtask

    // Result monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        pins_t got;
        pins_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = pins_t'(m_axis_tdata[14:0]);
            if (bus_expect.size() == 0)
            begin
                failures++;
                $display("%0t: result %0d arrived with none expected, got %0h",
                         $time, results_seen, m_axis_tdata);
            end
            else
            begin
                want = bus_expect.pop_front();
                note_field("scl_level", 8'(want.scl), 8'(got.scl));
                note_field("sda_level", 8'(want.sda), 8'(got.sda));
                note_field("sda_drive", 8'(want.oe), 8'(got.oe));
                note_field("busy_res", 8'(want.busy), 8'(got.busy));
                note_field("done_res", 8'(want.done), 8'(got.done));
                note_field("rd_data", want.rd, got.rd);
                note_field("ack_received", 8'(want.ack), 8'(got.ack));
                note_field("ack_timed_out", 8'(want.late), 8'(got.late));
            end
            results_seen++;
        end
    end

    // Watchdog: count cycles in which neither side moves a request or a result
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic push_tick(logic take, i2cm_pkg::cmd_t kind, logic [7:0] data, logic nack,
                             logic sda);
        tick_t t;
        t.take = take;
        t.kind = kind;
        t.data = data;
        t.nack = nack;
        t.sda  = sda;
        pending.push_back(t);
        queued_ticks++;
    endtask

    // Idle tick with random content in the unused fields
    task automatic push_idle(logic sda);
        push_tick(1'b0, i2cm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                  sda);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue one command and the ticks that carry it to completion.
    // A write's SDA stays high for ack_at polls and then drops; past the budget it times out.
    // sda_fix forces the read bits, poke_at places a command inside the busy stretch,
    // trim cuts the stretch short so that the next command lands early.
    task automatic issue(i2cm_pkg::cmd_t kind, logic [7:0] data, logic nack, int ack_at,
                         int sda_fix, int poke_at, int trim);
        int   dly;
        int   first_poll;
        int   tmo;
        int   span;
        int   i;
        logic s;
        dly = (cfg_delay == 16'd0) ? 1 : int'(cfg_delay);
        first_poll = 26 * dly + 1;
        tmo = int'(cfg_timeout);
        case (kind)
            i2cm_pkg::CMD_START, i2cm_pkg::CMD_STOP: span = 2 * dly + 1;
            i2cm_pkg::CMD_WRITE: span = (ack_at <= tmo) ? first_poll + ack_at
                                                        : first_poll + tmo + 2 * dly + 1;
            default: span = 19 * dly + 1;
        endcase
        span = (span - trim < 1) ? 1 : span - trim;
        push_tick(1'b1, kind, data, nack, 1'($urandom));
        for (i = 1; i <= span; i++)
        begin
            if (kind == i2cm_pkg::CMD_WRITE && i >= first_poll && i <= first_poll + tmo)
                s = (i - first_poll) < ack_at;
            else if (kind == i2cm_pkg::CMD_READ && sda_fix >= 0)
                s = sda_fix[0];
            else
                s = 1'($urandom);
            push_tick(i == poke_at, i2cm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom), s);
        end
    endtask

    // Hold until every queued request is taken and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || s_axis_tvalid || bus_expect.size() != 0);
    endtask

    // Drain, pad with idle ticks until the sequencer is idle, then let the pipeline settle
    task automatic settle_idle();
        wait_drained();
        while (m_seq != SEQ_IDLE)
        begin
            repeat (16) push_idle(1'b0);
            wait_drained();
        end
        repeat (4) @(negedge clk);
    endtask

    // Write both registers on consecutive cycles
    task automatic set_config(logic [15:0] dly, logic [7:0] tmo);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= i2cm_pkg::CFG_DELAY;
        cfg_wdata <= dly;
        @(posedge clk);
        cfg_addr <= i2cm_pkg::CFG_TIMEOUT;
        cfg_wdata <= {8'd0, tmo};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_delay = dly;
        cfg_timeout = tmo;
        configs_applied++;
        repeat (2) @(negedge clk);
    endtask

    // Random stretch at one configuration: mostly whole commands, some noise and early commands
    task automatic random_phase(logic [15:0] dly, logic [7:0] tmo);
        int             start;
        int             roll;
        int             tmo_i;
        int             ack_at;
        int             sda_fix;
        int             poke_at;
        int             trim;
        i2cm_pkg::cmd_t kind;
        settle_idle();
        set_config(dly, tmo);
        tmo_i = int'(tmo);
        start = queued_ticks;
        while (queued_ticks - start < RANDOM_TICKS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                wait_drained();
            end
            else if (roll < 14)
            begin
                repeat ($urandom_range(1, 6))
                    push_tick($urandom_range(0, 3) == 0,
                              i2cm_pkg::cmd_t'($urandom_range(0, 3)),
                              8'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                kind = i2cm_pkg::cmd_t'($urandom_range(0, 3));
                ack_at = ($urandom_range(0, 3) == 0) ? tmo_i + 1 : $urandom_range(0, tmo_i + 1);
                sda_fix = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : -1;
                poke_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : -1;
                trim = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
                issue(kind, pick_byte(), 1'($urandom), ack_at, sda_fix, poke_at, trim);
                repeat ($urandom_range(0, 3)) push_idle(1'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset configuration: slow edges; a command lands while busy
        issue(i2cm_pkg::CMD_START, 8'h00, 1'b0, 0, -1, 5, 0);
        issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 0, -1, -1, 0);

        // Zero spacing and zero ACK budget: first high poll already gives up
        settle_idle();
        set_config(16'd0, 8'd0);
        issue(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1, -1, -1, 0);
        issue(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, 0, -1, -1, 0);
        issue(i2cm_pkg::CMD_READ, 8'h5A, 1'b0, 0, 1, -1, 0);
        issue(i2cm_pkg::CMD_READ, 8'hA5, 1'b1, 0, 0, -1, 0);
        issue(i2cm_pkg::CMD_START, 8'hFF, 1'b1, 0, -1, -1, 0);
        issue(i2cm_pkg::CMD_STOP, 8'hFF, 1'b1, 0, -1, -1, 0);

        // Widest ACK budget at the tightest spacing: the wait gives up on the last poll
        settle_idle();
        set_config(16'd1, 8'd255);
        issue(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 256, -1, -1, 0);

        // Random traffic over several settings
        random_phase(16'd1, 8'd1);
        random_phase(16'd0, 8'd4);
        random_phase(16'd2, 8'd0);
        random_phase(16'd1, 8'd7);

        wait_drained();
        repeat (10) @(negedge clk);
        $display("Ran %0d ticks: %0d start, %0d stop, %0d write and %0d read commands taken",
                 results_seen, cmd_taken[int'(i2cm_pkg::CMD_START)],
                 cmd_taken[int'(i2cm_pkg::CMD_STOP)], cmd_taken[int'(i2cm_pkg::CMD_WRITE)],
                 cmd_taken[int'(i2cm_pkg::CMD_READ)]);
        $display("Writes acknowledged %0d, ACK waits expired %0d, register settings %0d",
                 acks_seen, timeouts_seen, configs_applied);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== i2c_master_byte_engine.f =====
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_seq.sv
sv/i2c_master_byte_engine.sv
tb/sv/i2c_master_byte_engine_tb.sv
